[hw/rtl/dsha_pkg.sv]
// shared types, constants and round functions for the double sha-512/256 nonce tester
package dsha_pkg;

	typedef logic [63:0] word64_t;
	typedef logic [15:0][63:0] blk_t;
	typedef logic [7:0][63:0] st_t;

	localparam int HDR_WORDS = 19;
	localparam int ROUNDS    = 80;
	localparam int TAG_W     = 32;

	// input item kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_NONCE = 1'b1;

	// configuration register indexes
	localparam logic [2:0] CFG_TARGET_Q0 = 3'd0;
	localparam logic [2:0] CFG_TARGET_Q1 = 3'd1;
	localparam logic [2:0] CFG_TARGET_Q2 = 3'd2;
	localparam logic [2:0] CFG_TARGET_Q3 = 3'd3;
	localparam logic [2:0] CFG_SUPPRESS  = 3'd4;

	localparam word64_t PAD_BIT  = 64'h8000000000000000;
	localparam word64_t LEN_HDR  = 64'd640;
	localparam word64_t LEN_DIG  = 64'd256;

	localparam st_t IV = {
		64'h0EB72DDC81C52CA2, 64'h2B0199FC2C85B8AA,
		64'hBE5E1E2553863992, 64'h96283EE2A88EFFE3,
		64'h963877195940EABD, 64'h2393B86B6F53B151,
		64'h9F555FA3C84C64C2, 64'h22312194FC2BF72C
	};

	localparam word64_t K [ROUNDS] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	function automatic word64_t rotr(input word64_t x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	// one compression round; st[0] is a, st[7] is h
	function automatic st_t round_step(input st_t st, input word64_t w, input word64_t k);
		word64_t t1;
		word64_t t2;
		st_t r;
		t1 = st[7] + (rotr(st[4], 14) ^ rotr(st[4], 18) ^ rotr(st[4], 41))
			+ ((st[4] & st[5]) ^ (~st[4] & st[6])) + k + w;
		t2 = (rotr(st[0], 28) ^ rotr(st[0], 34) ^ rotr(st[0], 39))
			+ ((st[0] & st[1]) ^ (st[0] & st[2]) ^ (st[1] & st[2]));
		r[0] = t1 + t2;
		r[1] = st[0];
		r[2] = st[1];
		r[3] = st[2];
		r[4] = st[3] + t1;
		r[5] = st[4];
		r[6] = st[5];
		r[7] = st[6];
		return r;
	endfunction

	// slide the 16-word schedule window by one word
	function automatic blk_t sched_step(input blk_t w);
		word64_t s0;
		word64_t s1;
		blk_t r;
		s0 = rotr(w[1], 1) ^ rotr(w[1], 8) ^ (w[1] >> 7);
		s1 = rotr(w[14], 19) ^ rotr(w[14], 61) ^ (w[14] >> 6);
		for (int i = 0; i < 15; i++) begin
			r[i] = w[i + 1];
		end
		r[15] = w[0] + s0 + w[9] + s1;
		return r;
	endfunction

	function automatic word64_t swap64(input word64_t x);
		word64_t r;
		for (int i = 0; i < 8; i++) begin
			r[8*i +: 8] = x[8*(7-i) +: 8];
		end
		return r;
	endfunction

endpackage

[hw/rtl/dsha_ifs.sv]
// channel interfaces: nonce/header items in, test results out
interface dsha_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [4:0]  word_index;
	logic [31:0] word_value;
	logic [31:0] nonce;
	modport source (output valid, kind, word_index, word_value, nonce, input ready);
	modport sink (input valid, kind, word_index, word_value, nonce, output ready);
endinterface

interface dsha_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] tested_nonce;
	logic        hit;
	logic [63:0] digest_q0;
	logic [63:0] digest_q1;
	logic [63:0] digest_q2;
	logic [63:0] digest_q3;
	modport source (output valid, tested_nonce, hit, digest_q0, digest_q1, digest_q2,
		digest_q3, input ready);
	modport sink (input valid, tested_nonce, hit, digest_q0, digest_q1, digest_q2,
		digest_q3, output ready);
endinterface

[hw/rtl/dsha_comp.sv]
// fully unrolled sha-512/256 compression pipeline, one round per stage
module dsha_comp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  dsha_pkg::blk_t            in_blk,
	input  logic [dsha_pkg::TAG_W-1:0] in_tag,
	output logic                      out_vld,
	output dsha_pkg::st_t             out_st,
	output logic [dsha_pkg::TAG_W-1:0] out_tag
);

	logic                       vld_s [dsha_pkg::ROUNDS+1];
	dsha_pkg::st_t              st_s  [dsha_pkg::ROUNDS+1];
	dsha_pkg::blk_t             w_s   [dsha_pkg::ROUNDS+1];
	logic [dsha_pkg::TAG_W-1:0] tag_s [dsha_pkg::ROUNDS+1];
	logic                       vld_fin_s;
	dsha_pkg::st_t              st_fin_s;
	logic [dsha_pkg::TAG_W-1:0] tag_fin_s;

	// entry stage: block and initial state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0]  <= dsha_pkg::IV;
			w_s[0]   <= in_blk;
			tag_s[0] <= in_tag;
		end
	end

	// round stages
	for (genvar r = 0; r < dsha_pkg::ROUNDS; r++) begin : g_round
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[r+1] <= 1'b0;
			end else if (en) begin
				vld_s[r+1] <= vld_s[r];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[r+1]  <= dsha_pkg::round_step(st_s[r], w_s[r][0], dsha_pkg::K[r]);
				w_s[r+1]   <= dsha_pkg::sched_step(w_s[r]);
				tag_s[r+1] <= tag_s[r];
			end
		end
	end

	// feed-forward add of the initial state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_fin_s <= 1'b0;
		end else if (en) begin
			vld_fin_s <= vld_s[dsha_pkg::ROUNDS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 8; j++) begin
				st_fin_s[j] <= dsha_pkg::IV[j] + st_s[dsha_pkg::ROUNDS][j];
			end
			tag_fin_s <= tag_s[dsha_pkg::ROUNDS];
		end
	end

	assign out_vld = vld_fin_s;
	assign out_st  = st_fin_s;
	assign out_tag = tag_fin_s;

endmodule

[hw/rtl/double_sha512_256_nonce_test.sv]
// top level: header store, two chained sha-512/256 pipelines, target compare
//
//  channel | dir | transfer when      | payload
//  in      | in  | valid & ready      | kind, word_index, word_value, nonce
//  out     | out | valid & ready      | tested_nonce, hit, digest_q0..q3
//  cfg     | in  | cfg_we             | cfg_index, cfg_data
//
// one nonce enters per cycle while the pipeline is not held; each compression pipeline has
// 82 stages (entry, 80 rounds, feed-forward add), followed by the output register.
// a header load is accepted like a nonce and makes no result.
// reset clears valid bits and configuration; header words are undefined until loaded.
// when the output register is full and not taken, the whole pipeline holds.
module double_sha512_256_nonce_test (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	dsha_in_if.sink     in,
	dsha_out_if.source  out
);

	logic [31:0]    hdr_q [dsha_pkg::HDR_WORDS];
	logic [63:0]    target_q [4];
	logic           suppress_q;
	logic           en;
	logic           acc;
	dsha_pkg::blk_t blk1;
	dsha_pkg::blk_t blk2;
	logic           vld1;
	dsha_pkg::st_t  st1;
	logic [31:0]    tag1;
	logic           vld2;
	dsha_pkg::st_t  st2;
	logic [31:0]    tag2;
	logic [255:0]   dig;
	logic           out_vld_q;
	logic [31:0]    nonce_q;
	logic           hit_q;
	logic [255:0]   dig_q;

	// pipeline advances unless a result waits untaken
	assign en       = !out_vld_q || out.ready;
	assign in.ready = en;
	assign acc      = in.valid && en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				target_q[i] <= 64'd0;
			end
			suppress_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dsha_pkg::CFG_TARGET_Q0: target_q[0] <= cfg_data;
				dsha_pkg::CFG_TARGET_Q1: target_q[1] <= cfg_data;
				dsha_pkg::CFG_TARGET_Q2: target_q[2] <= cfg_data;
				dsha_pkg::CFG_TARGET_Q3: target_q[3] <= cfg_data;
				dsha_pkg::CFG_SUPPRESS:  suppress_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// header word store
	always_ff @(posedge clk) begin
		if (acc && in.kind == dsha_pkg::KIND_LOAD && in.word_index < 5'(dsha_pkg::HDR_WORDS)) begin
			hdr_q[in.word_index] <= in.word_value;
		end
	end

	// first block: 80-byte header with nonce, padded
	always_comb begin
		blk1 = '0;
		for (int i = 0; i < 9; i++) begin
			blk1[i] = {hdr_q[2*i], hdr_q[2*i+1]};
		end
		blk1[9]  = {hdr_q[18], in.nonce};
		blk1[10] = dsha_pkg::PAD_BIT;
		blk1[15] = dsha_pkg::LEN_HDR;
	end

	dsha_comp u_comp1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (acc && in.kind == dsha_pkg::KIND_NONCE),
		.in_blk  (blk1),
		.in_tag  (in.nonce),
		.out_vld (vld1),
		.out_st  (st1),
		.out_tag (tag1)
	);

	// second block: 32-byte digest, padded
	always_comb begin
		blk2 = '0;
		for (int i = 0; i < 4; i++) begin
			blk2[i] = st1[i];
		end
		blk2[4]  = dsha_pkg::PAD_BIT;
		blk2[15] = dsha_pkg::LEN_DIG;
	end

	dsha_comp u_comp2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld1),
		.in_blk  (blk2),
		.in_tag  (tag1),
		.out_vld (vld2),
		.out_st  (st2),
		.out_tag (tag2)
	);

	// digest as little-endian 256-bit number
	assign dig = {dsha_pkg::swap64(st2[3]), dsha_pkg::swap64(st2[2]),
		dsha_pkg::swap64(st2[1]), dsha_pkg::swap64(st2[0])};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nonce_q <= tag2;
			dig_q   <= dig;
			hit_q   <= !suppress_q &&
				(dig <= {target_q[3], target_q[2], target_q[1], target_q[0]});
		end
	end

	assign out.valid        = out_vld_q;
	assign out.tested_nonce = nonce_q;
	assign out.hit          = hit_q;
	assign out.digest_q0    = dig_q[63:0];
	assign out.digest_q1    = dig_q[127:64];
	assign out.digest_q2    = dig_q[191:128];
	assign out.digest_q3    = dig_q[255:192];

endmodule

[bench/tb.sv]
// testbench for the double sha-512/256 nonce tester: random and directed items, scoreboard check
`timescale 1ns / 100ps

module tb;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_WAIT  = 200;

	localparam logic [63:0] ROUND_K [80] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	localparam logic [63:0] START_H [8] = '{
		64'h22312194FC2BF72C, 64'h9F555FA3C84C64C2, 64'h2393B86B6F53B151, 64'h963877195940EABD,
		64'h96283EE2A88EFFE3, 64'hBE5E1E2553863992, 64'h2B0199FC2C85B8AA, 64'h0EB72DDC81C52CA2
	};

	typedef logic [15:0][63:0] msg_block_t;
	typedef logic [7:0][63:0]  chain_t;

	typedef struct {
		logic [31:0]  nonce;
		logic         hit;
		logic [255:0] digest;
	} pow_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [63:0] cfg_data;
	int errors;
	int cycles;
	int loads_sent;
	bit burst;

	dsha_in_if  in_ch ();
	dsha_out_if out_ch ();

	double_sha512_256_nonce_test dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in(in_ch.sink), .out(out_ch.source)
	);

	function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	function automatic logic [63:0] byte_rev(input logic [63:0] x);
		logic [63:0] r;
		for (int i = 0; i < 8; i++) r[8*i +: 8] = x[56 - 8*i +: 8];
		return r;
	endfunction

	// one sha-512 compression of a single block from the sha-512/256 start value
	function automatic chain_t sha_block(input msg_block_t blk);
		logic [63:0] w [80];
		logic [63:0] v [8];
		logic [63:0] t1, t2, s0, s1;
		chain_t r;
		for (int i = 0; i < 16; i++) w[i] = blk[i];
		for (int i = 16; i < 80; i++) begin
			s0 = ror64(w[i-15], 1) ^ ror64(w[i-15], 8) ^ (w[i-15] >> 7);
			s1 = ror64(w[i-2], 19) ^ ror64(w[i-2], 61) ^ (w[i-2] >> 6);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		for (int i = 0; i < 8; i++) v[i] = START_H[i];
		for (int i = 0; i < 80; i++) begin
			t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
			t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int j = 7; j > 0; j--) v[j] = v[j-1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) r[i] = START_H[i] + v[i];
		return r;
	endfunction

	task automatic report(input string what, input logic [255:0] got, input logic [255:0] want);
		errors++;
		$display("ERROR %0t: %s got %h want %h", $time, what, got, want);
	endtask

	// scoreboard: header mirror, target mirror and expected results in order
	class pow_scoreboard;
		logic [31:0]  header [19];
		logic [255:0] target;
		logic         suppress;
		pow_result_t  expected_q [$];
		int nonces;
		int hits;

		function logic [255:0] hash_nonce(input logic [31:0] nonce);
			msg_block_t blk;
			chain_t st;
			blk = '0;
			for (int i = 0; i < 9; i++) blk[i] = {header[2*i], header[2*i+1]};
			blk[9] = {header[18], nonce};
			blk[10] = 64'h8000000000000000;
			blk[15] = 64'd640;
			st = sha_block(blk);
			blk = '0;
			for (int i = 0; i < 4; i++) blk[i] = st[i];
			blk[4] = 64'h8000000000000000;
			blk[15] = 64'd256;
			st = sha_block(blk);
			return {byte_rev(st[3]), byte_rev(st[2]), byte_rev(st[1]), byte_rev(st[0])};
		endfunction

		function void note_input(input logic kind, input logic [4:0] idx,
				input logic [31:0] val, input logic [31:0] nonce);
			pow_result_t r;
			if (kind == dsha_pkg::KIND_LOAD) begin
				if (idx < dsha_pkg::HDR_WORDS) header[idx] = val;
			end else begin
				r.nonce = nonce;
				r.digest = hash_nonce(nonce);
				r.hit = (r.digest <= target) && !suppress;
				nonces++;
				if (r.hit) hits++;
				expected_q.push_back(r);
			end
		endfunction

		task check_result(input pow_result_t got);
			pow_result_t want;
			if (expected_q.size() == 0) begin
				report("result with nothing expected, nonce", 256'(got.nonce), 256'd0);
			end else begin
				want = expected_q.pop_front();
				if (got.nonce !== want.nonce)
					report("tested_nonce", 256'(got.nonce), 256'(want.nonce));
				if (got.hit !== want.hit) report("hit", 256'(got.hit), 256'(want.hit));
				if (got.digest[63:0] !== want.digest[63:0])
					report("digest_q0", 256'(got.digest[63:0]), 256'(want.digest[63:0]));
				if (got.digest[127:64] !== want.digest[127:64])
					report("digest_q1", 256'(got.digest[127:64]), 256'(want.digest[127:64]));
				if (got.digest[191:128] !== want.digest[191:128])
					report("digest_q2", 256'(got.digest[191:128]), 256'(want.digest[191:128]));
				if (got.digest[255:192] !== want.digest[255:192])
					report("digest_q3", 256'(got.digest[255:192]), 256'(want.digest[255:192]));
			end
		endtask
	endclass

	pow_scoreboard sb = new();

	// clock and cycle limit
	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("double_sha512_256_nonce_test: mismatch");
			$finish;
		end
	end

	// result receiver with random stalls
	initial begin
		int stall;
		out_ch.ready <= 1'b0;
		forever begin
			stall = burst ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!(out_ch.valid === 1'b1 && arst_n));
		end
	end

	// result monitor
	always @(posedge clk) begin
		pow_result_t got;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
			got.nonce = out_ch.tested_nonce;
			got.hit = out_ch.hit;
			got.digest = {out_ch.digest_q3, out_ch.digest_q2, out_ch.digest_q1, out_ch.digest_q0};
			sb.check_result(got);
		end
	end

	task automatic send_item(input logic kind, input logic [4:0] idx,
			input logic [31:0] val, input logic [31:0] nonce);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= kind;
		in_ch.word_index <= idx;
		in_ch.word_value <= val;
		in_ch.nonce <= nonce;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sb.note_input(kind, idx, val, nonce);
		if (kind == dsha_pkg::KIND_LOAD) loads_sent++;
	endtask

	task automatic send_nonce(input logic [31:0] nonce);
		send_item(dsha_pkg::KIND_NONCE, 5'($urandom), $urandom, nonce);
	endtask

	task automatic load_header();
		for (int i = 0; i < dsha_pkg::HDR_WORDS; i++)
			send_item(dsha_pkg::KIND_LOAD, 5'(i), $urandom, $urandom);
	endtask

	// wait for every expected result, then for the pipeline to go quiet
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.expected_q.size() > 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			dsha_pkg::CFG_TARGET_Q0: sb.target[63:0] = data;
			dsha_pkg::CFG_TARGET_Q1: sb.target[127:64] = data;
			dsha_pkg::CFG_TARGET_Q2: sb.target[191:128] = data;
			dsha_pkg::CFG_TARGET_Q3: sb.target[255:192] = data;
			dsha_pkg::CFG_SUPPRESS:  sb.suppress = data[0];
			default: ;
		endcase
	endtask

	task automatic set_target(input logic [255:0] t, input logic sup);
		write_reg(dsha_pkg::CFG_TARGET_Q0, t[63:0]);
		write_reg(dsha_pkg::CFG_TARGET_Q1, t[127:64]);
		write_reg(dsha_pkg::CFG_TARGET_Q2, t[191:128]);
		write_reg(dsha_pkg::CFG_TARGET_Q3, t[255:192]);
		write_reg(dsha_pkg::CFG_SUPPRESS, {63'($urandom), sup});
	endtask

	// one random phase: mostly nonces, some header rewrites and stray loads
	task automatic random_phase(input int count, input bit pause);
		int pick;
		for (int n = 0; n < count; n++) begin
			if (n % 60 == 0) burst = ($urandom_range(0, 3) == 0);
			if (pause && n == count / 2) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
				while (sb.expected_q.size() > 0) @(posedge clk);
			end
			pick = $urandom_range(0, 99);
			if (pick < 86) send_nonce($urandom);
			else if (pick < 96)
				send_item(dsha_pkg::KIND_LOAD, 5'($urandom_range(0, 18)), $urandom, $urandom);
			else if (pick < 98)
				send_item(dsha_pkg::KIND_LOAD, 5'($urandom_range(19, 31)), $urandom, $urandom);
			else load_header();
		end
		burst = 1'b0;
	endtask

	initial begin
		logic [255:0] d;
		errors = 0;
		cycles = 0;
		loads_sent = 0;
		burst = 1'b0;
		sb.target = '0;
		sb.suppress = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.kind <= dsha_pkg::KIND_LOAD;
		in_ch.word_index <= '0;
		in_ch.word_value <= '0;
		in_ch.nonce <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero target, extreme header words and nonces, ignored loads
		set_target('0, 1'b0);
		send_item(dsha_pkg::KIND_LOAD, 5'd0, 32'h0, 32'hffffffff);
		send_item(dsha_pkg::KIND_LOAD, 5'd1, 32'hffffffff, 32'h0);
		for (int i = 2; i < dsha_pkg::HDR_WORDS; i++)
			send_item(dsha_pkg::KIND_LOAD, 5'(i), $urandom, $urandom);
		send_item(dsha_pkg::KIND_LOAD, 5'd19, 32'hffffffff, 32'h0);
		send_item(dsha_pkg::KIND_LOAD, 5'd31, 32'hffffffff, 32'h0);
		send_item(dsha_pkg::KIND_NONCE, 5'd31, 32'hffffffff, 32'h0);
		send_item(dsha_pkg::KIND_NONCE, 5'd0, 32'h0, 32'hffffffff);
		send_nonce(32'h1);
		send_nonce(32'h80000000);
		send_item(dsha_pkg::KIND_LOAD, 5'd18, 32'h12345678, 32'h0);
		send_nonce(32'h80000000);
		drain();

		// all-ones target: every digest hits, then the same with hits suppressed
		set_target('1, 1'b0);
		send_nonce(32'h0);
		send_nonce(32'hffffffff);
		drain();
		set_target('1, 1'b1);
		send_nonce(32'h0);
		send_nonce(32'hffffffff);
		drain();

		// target equal to the digest hits, one below it misses
		d = sb.hash_nonce(32'h5a5aa5a5);
		set_target(d, 1'b0);
		send_nonce(32'h5a5aa5a5);
		drain();
		set_target(d - 256'd1, 1'b0);
		send_nonce(32'h5a5aa5a5);
		drain();

		// random phases over several targets
		set_target({64'h2000000000000000 | 64'($urandom), 64'($urandom), 64'($urandom),
			64'($urandom)}, 1'b0);
		random_phase(170, 1'b1);
		drain();
		set_target('1, 1'b1);
		random_phase(170, 1'b0);
		drain();
		set_target('0, 1'b0);
		random_phase(170, 1'b0);
		drain();
		set_target({64'h8000000000000000, 192'h0}, 1'b0);
		random_phase(170, 1'b1);
		drain();

		while (sb.expected_q.size() > 0) begin
			report("no result for nonce", 256'(sb.expected_q[0].nonce), 256'd0);
			void'(sb.expected_q.pop_front());
		end
		$display("covered %0d nonce tests (%0d hits expected) and %0d header loads",
			sb.nonces, sb.hits, loads_sent);
		$display("targets zero, all ones, equal and just below a digest, random; suppression on and off");
		if (errors == 0) begin
			$display("double_sha512_256_nonce_test: match");
		end else begin
			$display("double_sha512_256_nonce_test: mismatch");
		end
		$finish;
	end

endmodule
